// File: rtl/mtrq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrq_pkg
// Shared types and constants of the minimum-timestamp request queue.
// ----------------------------------------------------------------------------
package mtrq_pkg;

	localparam int DEPTH   = 64;
	localparam int ID_W    = 32;
	localparam int TIME_W  = 48;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int ENTRY_W = 2 * ID_W + TIME_W;

	typedef enum logic [1:0] {
		REQ_ENQ   = 2'd0,
		REQ_DEQ   = 2'd1,
		REQ_QUERY = 2'd2,
		REQ_RSVD  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_EMPTY    = 2'd1,
		STS_FULL     = 2'd2,
		STS_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		logic [ID_W-1:0]   user;
		logic [ID_W-1:0]   session;
	} entry_t;

	typedef struct packed {
		status_t           status;
		entry_t            entry;
		logic [IDX_W-1:0]  position;
		logic [CNT_W-1:0]  count;
		logic              empty;
	} result_t;

endpackage

// File: rtl/min_timestamp_request_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_timestamp_request_queue
// Request queue kept in arrival order that serves the smallest timestamp first.
// ----------------------------------------------------------------------------
// From acceptance to the output register: an enqueue, a reserved request or a
// dequeue on an empty queue goes straight to the result; a query reads the held
// entries in order until one matches; a dequeue reads one per held entry for the
// scan and one per later entry for the shift.
// Throughput: one request at a time; the single RAM read port sets the rate.
// Reset clears the sequencer, the entry count and the output valid flag; the
// entry RAM is not cleared, as only entries below the count are ever read.
module min_timestamp_request_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,   // session_id[31:0], user_id[63:32], stamp[111:64]
	input  logic [1:0]   s_tuser,   // req_type[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // out_session[31:0], out_user[63:32], out_stamp[111:64],
	                                // position[117:112], entry_count[124:118],
	                                // queue_empty[125], zero[127:126]
	output logic [1:0]   m_tuser    // status[1:0]
);

	mtrq_pkg::entry_t                 in_entry;
	mtrq_pkg::result_t                rslt;
	mtrq_pkg::result_t                out_q;
	logic                             out_valid_q;
	logic                             rslt_valid;
	logic                             rslt_ready;
	logic                             ram_we;
	logic [mtrq_pkg::IDX_W-1:0]       ram_waddr;
	logic [mtrq_pkg::ENTRY_W-1:0]     ram_wdata;
	logic [mtrq_pkg::IDX_W-1:0]       ram_raddr;
	logic [mtrq_pkg::ENTRY_W-1:0]     ram_rdata;

	assign in_entry.session = s_tdata[31:0];
	assign in_entry.user    = s_tdata[63:32];
	assign in_entry.stamp   = s_tdata[111:64];

	mtrq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_kind    (mtrq_pkg::req_t'(s_tuser)),
		.in_entry   (in_entry),
		.rslt_valid (rslt_valid),
		.rslt_ready (rslt_ready),
		.rslt       (rslt),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	mtrq_ram #(
		.WIDTH (mtrq_pkg::ENTRY_W),
		.DEPTH (mtrq_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output register: a finished result waits here while the sequencer goes idle.
	assign rslt_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rslt_valid && rslt_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rslt_valid && rslt_ready) begin
			out_q <= rslt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {2'b00, out_q.empty, out_q.count, out_q.position,
		out_q.entry.stamp, out_q.entry.user, out_q.entry.session};

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while another is in progress");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == mtrq_pkg::STS_FULL)
			|-> (out_q.count == mtrq_pkg::CNT_W'(mtrq_pkg::DEPTH)))
		else $error("full status reported below full count");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.empty == (out_q.count == '0)))
		else $error("empty flag disagrees with entry count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.count <= mtrq_pkg::CNT_W'(mtrq_pkg::DEPTH)))
		else $error("entry count beyond depth");

endmodule

// File: rtl/mtrq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mtrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/mtrq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrq_ctrl
// Request sequencer: appends, scans the store and shifts entries down.
// ----------------------------------------------------------------------------
module mtrq_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  mtrq_pkg::req_t                in_kind,
	input  mtrq_pkg::entry_t              in_entry,
	output logic                          rslt_valid,
	input  logic                          rslt_ready,
	output mtrq_pkg::result_t             rslt,
	output logic                          ram_we,
	output logic [mtrq_pkg::IDX_W-1:0]    ram_waddr,
	output logic [mtrq_pkg::ENTRY_W-1:0]  ram_wdata,
	output logic [mtrq_pkg::IDX_W-1:0]    ram_raddr,
	input  logic [mtrq_pkg::ENTRY_W-1:0]  ram_rdata
);

	mtrq_pkg::state_t                 state_q, state_d;
	logic [mtrq_pkg::CNT_W-1:0]       count_q;
	logic [mtrq_pkg::CNT_W-1:0]       addr_q;
	logic                             rvalid_q;
	logic [mtrq_pkg::IDX_W-1:0]       ridx_q;
	mtrq_pkg::req_t                   kind_q;
	logic [mtrq_pkg::ID_W-1:0]        sess_q;
	mtrq_pkg::entry_t                 best_q;
	logic [mtrq_pkg::IDX_W-1:0]       best_idx_q;
	logic [mtrq_pkg::IDX_W-1:0]       pos_q;
	mtrq_pkg::status_t                status_q;
	mtrq_pkg::entry_t                 rd_e;
	logic                             accept;
	logic                             full;
	logic                             issue;
	logic                             match;
	logic                             scan_end;

	assign rd_e     = mtrq_pkg::entry_t'(ram_rdata);
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == mtrq_pkg::CNT_W'(mtrq_pkg::DEPTH));
	assign match    = rvalid_q && (kind_q == mtrq_pkg::REQ_QUERY) && (rd_e.session == sess_q);
	assign scan_end = !issue && !rvalid_q;
	assign ram_raddr = addr_q[mtrq_pkg::IDX_W-1:0];

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		rslt_valid = 1'b0;
		issue      = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = count_q[mtrq_pkg::IDX_W-1:0];
		ram_wdata  = in_entry;
		unique case (state_q)
			mtrq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_kind)
						mtrq_pkg::REQ_ENQ: begin
							ram_we  = !full;
							state_d = mtrq_pkg::ST_DONE;
						end
						mtrq_pkg::REQ_DEQ: begin
							state_d = (count_q == '0) ? mtrq_pkg::ST_DONE : mtrq_pkg::ST_SCAN;
						end
						mtrq_pkg::REQ_QUERY: state_d = mtrq_pkg::ST_SCAN;
						default:             state_d = mtrq_pkg::ST_DONE;
					endcase
				end
			end
			mtrq_pkg::ST_SCAN: begin
				issue = (addr_q < count_q);
				if (match) begin
					state_d = mtrq_pkg::ST_DONE;
				end else if (scan_end) begin
					state_d = (kind_q == mtrq_pkg::REQ_DEQ) ? mtrq_pkg::ST_SHIFT
						: mtrq_pkg::ST_DONE;
				end
			end
			mtrq_pkg::ST_SHIFT: begin
				// Entry read last cycle moves down one place while the next one is read.
				issue     = (addr_q < count_q);
				ram_we    = rvalid_q;
				ram_waddr = ridx_q - mtrq_pkg::IDX_W'(1);
				ram_wdata = ram_rdata;
				if (scan_end) begin
					state_d = mtrq_pkg::ST_DONE;
				end
			end
			mtrq_pkg::ST_DONE: begin
				rslt_valid = 1'b1;
				if (rslt_ready) begin
					state_d = mtrq_pkg::ST_IDLE;
				end
			end
			default: state_d = mtrq_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mtrq_pkg::ST_IDLE;
			count_q  <= '0;
			addr_q   <= '0;
			rvalid_q <= 1'b0;
			status_q <= mtrq_pkg::STS_OK;
		end else begin
			state_q  <= state_d;
			rvalid_q <= issue && (state_d == state_q);
			if (accept) begin
				addr_q <= '0;
				if (in_kind == mtrq_pkg::REQ_ENQ && full) begin
					status_q <= mtrq_pkg::STS_FULL;
				end else if (in_kind == mtrq_pkg::REQ_DEQ && count_q == '0) begin
					status_q <= mtrq_pkg::STS_EMPTY;
				end else begin
					status_q <= mtrq_pkg::STS_OK;
				end
				if (in_kind == mtrq_pkg::REQ_ENQ && !full) begin
					count_q <= count_q + mtrq_pkg::CNT_W'(1);
				end
			end else if (state_q == mtrq_pkg::ST_SCAN && !match && scan_end) begin
				if (kind_q == mtrq_pkg::REQ_DEQ) begin
					addr_q <= {1'b0, best_idx_q} + mtrq_pkg::CNT_W'(1);
				end else begin
					status_q <= mtrq_pkg::STS_NOTFOUND;
				end
			end else if (issue) begin
				addr_q <= addr_q + mtrq_pkg::CNT_W'(1);
			end
			if (state_q == mtrq_pkg::ST_SHIFT && scan_end) begin
				count_q <= count_q - mtrq_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ridx_q <= addr_q[mtrq_pkg::IDX_W-1:0];
		end
		if (accept) begin
			kind_q <= in_kind;
			sess_q <= in_entry.session;
			best_q <= '0;
			pos_q  <= '0;
		end else if (state_q == mtrq_pkg::ST_SCAN && rvalid_q) begin
			if (kind_q == mtrq_pkg::REQ_DEQ) begin
				// Strict compare keeps the earliest-stored entry on equal stamps.
				if (ridx_q == '0 || rd_e.stamp < best_q.stamp) begin
					best_q     <= rd_e;
					best_idx_q <= ridx_q;
				end
			end else if (match) begin
				pos_q <= ridx_q;
			end
		end
	end

	always_comb begin
		rslt.status   = status_q;
		rslt.entry    = best_q;
		rslt.position = pos_q;
		rslt.count    = count_q;
		rslt.empty    = (count_q == '0);
	end

endmodule

// File: tb/request_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// request_queue_checker
// Watches both streams of the request queue, keeps its own copy of the held
// entries, works out the result of every accepted request and compares each
// returned result, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module request_queue_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [111:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [127:0] m_tdata,
	input  logic [1:0]   m_tuser,
	output int           failures,
	output int           outstanding,
	output int           results_checked,
	output int           full_drops,
	output int           empty_dequeues,
	output int           missed_queries,
	output int           peak_held
);

	logic [mtrq_pkg::ID_W-1:0]   held_session [mtrq_pkg::DEPTH];
	logic [mtrq_pkg::ID_W-1:0]   held_user    [mtrq_pkg::DEPTH];
	logic [mtrq_pkg::TIME_W-1:0] held_stamp   [mtrq_pkg::DEPTH];
	int                          held_total;
	mtrq_pkg::result_t           awaited_results [$];

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH at %0t, result %0d, %s: got %0h, expected %0h",
			$realtime, results_checked, what, got, want);
		failures++;
	endtask

	task automatic serve_request(input mtrq_pkg::req_t kind,
			input logic [mtrq_pkg::ID_W-1:0] sess,
			input logic [mtrq_pkg::ID_W-1:0] user,
			input logic [mtrq_pkg::TIME_W-1:0] stamp,
			output mtrq_pkg::result_t res);
		int best;
		res = '0;
		case (kind)
			mtrq_pkg::REQ_ENQ: begin
				if (held_total >= mtrq_pkg::DEPTH) begin
					res.status = mtrq_pkg::STS_FULL;
					full_drops++;
				end else begin
					held_session[held_total] = sess;
					held_user[held_total]    = user;
					held_stamp[held_total]   = stamp;
					held_total++;
				end
			end
			mtrq_pkg::REQ_DEQ: begin
				if (held_total == 0) begin
					res.status = mtrq_pkg::STS_EMPTY;
					empty_dequeues++;
				end else begin
					// Strictly smaller only, so the lowest index wins a tie.
					best = 0;
					for (int i = 1; i < held_total; i++)
						if (held_stamp[i] < held_stamp[best])
							best = i;
					res.entry.session = held_session[best];
					res.entry.user    = held_user[best];
					res.entry.stamp   = held_stamp[best];
					for (int i = best; i + 1 < held_total; i++) begin
						held_session[i] = held_session[i + 1];
						held_user[i]    = held_user[i + 1];
						held_stamp[i]   = held_stamp[i + 1];
					end
					held_total--;
				end
			end
			mtrq_pkg::REQ_QUERY: begin
				res.status = mtrq_pkg::STS_NOTFOUND;
				for (int i = 0; i < held_total; i++) begin
					if (held_session[i] == sess) begin
						res.status   = mtrq_pkg::STS_OK;
						res.position = mtrq_pkg::IDX_W'(i);
						break;
					end
				end
				if (res.status == mtrq_pkg::STS_NOTFOUND)
					missed_queries++;
			end
			default: ;
		endcase
		res.count = mtrq_pkg::CNT_W'(held_total);
		res.empty = (held_total == 0);
		if (held_total > peak_held)
			peak_held = held_total;
	endtask

	task automatic check_result();
		mtrq_pkg::result_t want;
		if (awaited_results.size() == 0) begin
			flag_mismatch("result with no request outstanding", m_tdata[63:0], 64'd0);
			return;
		end
		want = awaited_results.pop_front();
		if (m_tuser != want.status)
			flag_mismatch("status", 64'(m_tuser), 64'(want.status));
		if (m_tdata[31:0] != want.entry.session)
			flag_mismatch("out_session", 64'(m_tdata[31:0]), 64'(want.entry.session));
		if (m_tdata[63:32] != want.entry.user)
			flag_mismatch("out_user", 64'(m_tdata[63:32]), 64'(want.entry.user));
		if (m_tdata[111:64] != want.entry.stamp)
			flag_mismatch("out_stamp", 64'(m_tdata[111:64]), 64'(want.entry.stamp));
		if (m_tdata[117:112] != want.position)
			flag_mismatch("position", 64'(m_tdata[117:112]), 64'(want.position));
		if (m_tdata[124:118] != want.count)
			flag_mismatch("entry_count", 64'(m_tdata[124:118]), 64'(want.count));
		if (m_tdata[125] != want.empty)
			flag_mismatch("queue_empty", 64'(m_tdata[125]), 64'(want.empty));
		if (m_tdata[127:126] != 2'b00)
			flag_mismatch("padding", 64'(m_tdata[127:126]), 64'd0);
		results_checked++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		mtrq_pkg::result_t res;
		if (!arst_n) begin
			held_total = 0;
			awaited_results.delete();
			failures = 0;
			results_checked = 0;
			full_drops = 0;
			empty_dequeues = 0;
			missed_queries = 0;
			peak_held = 0;
		end else begin
			// The block serves one request at a time, but a result can wait in the output
			// register while the next one is accepted, so predictions wait in a queue.
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready) begin
				serve_request(mtrq_pkg::req_t'(s_tuser), s_tdata[31:0], s_tdata[63:32],
					s_tdata[111:64], res);
				awaited_results.insert(awaited_results.size(), res);
			end
		end
		outstanding = awaited_results.size();
	end

endmodule

// File: tb/min_timestamp_request_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_timestamp_request_queue_tb
// Drives enqueue, dequeue, position query and reserved requests into the
// queue: a directed opening on the corner cases, then random phases that fill
// the store to full, drain it to empty and mix the two, with bursty requests
// and a stalling result side. The checker beside the block judges each result.
// ----------------------------------------------------------------------------
module min_timestamp_request_queue_tb;

	localparam int REQUEST_TOTAL = 1350;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 200;

	typedef enum logic [1:0] {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} mix_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [111:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic [1:0]   m_tuser;

	int failures, outstanding, results_checked;
	int full_drops, empty_dequeues, missed_queries, peak_held;

	int          quiet_cycles = 0;
	int unsigned ready_hold   = 0;
	int          burst_left   = 0;
	int          requests_sent = 0;
	logic [mtrq_pkg::ID_W-1:0] session_pool [8];

	min_timestamp_request_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	request_queue_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.failures        (failures),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.full_drops      (full_drops),
		.empty_dequeues  (empty_dequeues),
		.missed_queries  (missed_queries),
		.peak_held       (peak_held)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// The result side follows its own pattern: short stalls, long ready
	// stretches and stretches of random toggling.
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					m_tready   <= 1'b0;
					ready_hold <= $urandom_range(0, 20);
				end
				1: begin
					m_tready   <= 1'b1;
					ready_hold <= $urandom_range(100, 300);
				end
				default: begin
					m_tready   <= 1'($urandom_range(0, 1));
					ready_hold <= $urandom_range(0, 6);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("No transaction for %0d cycles at %0t", STALL_LIMIT, $realtime);
				$display("Some tests failed");
				$finish;
			end
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Called just after a rising edge; leaves s_tvalid high for a following request.
	task automatic send_request(input mtrq_pkg::req_t kind,
			input logic [mtrq_pkg::ID_W-1:0] sess,
			input logic [mtrq_pkg::ID_W-1:0] user,
			input logic [mtrq_pkg::TIME_W-1:0] stamp);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {stamp, user, sess};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (kind != mtrq_pkg::REQ_RSVD)
			requests_sent++;
	endtask

	function automatic logic [mtrq_pkg::ID_W-1:0] pick_session(input int pool_percent);
		if ($urandom_range(0, 99) < pool_percent)
			return session_pool[$urandom_range(0, 7)];
		return $urandom();
	endfunction

	function automatic logic [mtrq_pkg::TIME_W-1:0] pick_stamp();
		case ($urandom_range(0, 9))
			0, 1, 2: return mtrq_pkg::TIME_W'($urandom_range(0, 7));   // frequent ties
			3:       return ($urandom_range(0, 1) == 1) ? '1 : '0;
			default: return {16'($urandom()), 32'($urandom())};
		endcase
	endfunction

	function automatic mtrq_pkg::req_t pick_kind(input mix_t mix);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 2)
			return mtrq_pkg::REQ_RSVD;
		case (mix)
			MIX_FILL:  return (roll < 87) ? mtrq_pkg::REQ_ENQ
				: (roll < 92) ? mtrq_pkg::REQ_DEQ : mtrq_pkg::REQ_QUERY;
			MIX_DRAIN: return (roll < 17) ? mtrq_pkg::REQ_ENQ
				: (roll < 87) ? mtrq_pkg::REQ_DEQ : mtrq_pkg::REQ_QUERY;
			default:   return (roll < 42) ? mtrq_pkg::REQ_ENQ
				: (roll < 77) ? mtrq_pkg::REQ_DEQ : mtrq_pkg::REQ_QUERY;
		endcase
	endfunction

	initial begin
		mix_t           mix;
		int             phase_len;
		mtrq_pkg::req_t kind;

		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser  <= mtrq_pkg::REQ_ENQ;
		s_tdata  <= '0;
		session_pool[0] = '0;
		session_pool[7] = '1;
		for (int i = 1; i < 7; i++)
			session_pool[i] = $urandom();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: empty queue, field extremes, lookups, stamp ties.
		send_request(mtrq_pkg::REQ_DEQ,   '0, '0, '0);
		send_request(mtrq_pkg::REQ_QUERY, 32'h0000_0001, '0, '0);
		send_request(mtrq_pkg::REQ_RSVD,  '0, '0, '0);
		send_request(mtrq_pkg::REQ_ENQ,   32'h0000_0000, 32'h0000_0000, '1);
		send_request(mtrq_pkg::REQ_ENQ,   32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
		send_request(mtrq_pkg::REQ_ENQ,   32'hA5A5_A5A5, 32'h5A5A_5A5A, 48'h5555_5555_5555);
		send_request(mtrq_pkg::REQ_ENQ,   32'h1234_5678, 32'h8765_4321, '0);
		send_request(mtrq_pkg::REQ_QUERY, 32'hFFFF_FFFF, '0, '0);
		send_request(mtrq_pkg::REQ_QUERY, 32'h0000_0000, '0, '0);
		send_request(mtrq_pkg::REQ_QUERY, 32'h1234_5678, '0, '0);
		send_request(mtrq_pkg::REQ_QUERY, 32'hDEAD_BEEF, '0, '0);
		send_request(mtrq_pkg::REQ_RSVD,  '1, '1, '1);
		send_request(mtrq_pkg::REQ_ENQ,   32'h0000_0000, 32'hCAFE_F00D, 48'd100);
		send_request(mtrq_pkg::REQ_QUERY, 32'h0000_0000, '0, '0);
		send_request(mtrq_pkg::REQ_ENQ,   32'h5A5A_5A5A, 32'hA5A5_A5A5, 48'hAAAA_AAAA_AAAA);
		repeat (7)
			send_request(mtrq_pkg::REQ_DEQ, '0, '0, '0);
		send_request(mtrq_pkg::REQ_QUERY, 32'hFFFF_FFFF, '0, '0);

		// Random phases; the first one fills the store until enqueues are dropped.
		mix = MIX_FILL;
		phase_len = 110;
		while (requests_sent < REQUEST_TOTAL) begin
			for (int n = 0; n < phase_len && requests_sent < REQUEST_TOTAL; n++) begin
				kind = pick_kind(mix);
				case (kind)
					mtrq_pkg::REQ_ENQ:
						send_request(kind, pick_session(60), $urandom(), pick_stamp());
					mtrq_pkg::REQ_QUERY:
						send_request(kind, pick_session(75), $urandom(), pick_stamp());
					default:
						send_request(kind, $urandom(), $urandom(), pick_stamp());
				endcase
			end
			mix = mix_t'($urandom_range(0, 2));
			phase_len = $urandom_range(30, 150);
		end
		s_tvalid <= 1'b0;

		do
			@(negedge clk);
		while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);

		$display("Checked %0d results: %0d enqueues dropped on full, %0d dequeues on empty, %0d unmatched queries.",
			results_checked, full_drops, empty_dequeues, missed_queries);
		$display("Occupancy peaked at %0d of %0d entries.", peak_held, mtrq_pkg::DEPTH);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
